FILE: rtl/core/box_blur_3x3_clipped_core_macros.svh
// Assertion macros for the checker file of the box blur core.
`ifndef BOX_BLUR_3X3_CLIPPED_CORE_MACROS_SVH
`define BOX_BLUR_3X3_CLIPPED_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BBC_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BBC_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/bblur3_pkg.sv
// Package: shared types, constants and the reciprocal table of the box blur core.
`timescale 1ns / 1ps
package bblur3_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 4096;

    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int CFG_DATA_W = 13;

    localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
    localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    // Queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPW    = $clog2(QDEPTH);

    // Rounded mean: q = (num * recip) >> RECIP_SHIFT, exact for num < 2^13
    localparam int RECIP_SHIFT = 18;
    localparam int RECIP_W     = 18;
    localparam int NUM_W       = 13;
    localparam int SUM_W       = 12;
    localparam int COL_SUM_W   = 10;

    typedef enum logic {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } cfg_index_t;

    // red in [23:16], green in [15:8], blue in [7:0]
    typedef logic [23:0] pix_t;

    typedef struct packed {
        logic       valid;
        logic [2:0] col_mask;   // bit0 two left, bit1 one left, bit2 current column
        logic [2:0] row_mask;   // bit0 top, bit1 middle, bit2 bottom
        logic       flast;
    } job_t;

    // Window pixels: index col*3 + row
    typedef struct packed {
        pix_t [8:0] pix;
        job_t [3:0] job;
    } q_entry_t;

    // ceil(2^18 / (2*cnt))
    function automatic logic [RECIP_W-1:0] recip(input logic [3:0] cnt);
        logic [RECIP_W-1:0] r;
        unique case (cnt)
            4'd1:    r = 18'd131071 + 18'd1;
            4'd2:    r = 18'd65536;
            4'd3:    r = 18'd43691;
            4'd4:    r = 18'd32768;
            4'd5:    r = 18'd26215;
            4'd6:    r = 18'd21846;
            4'd7:    r = 18'd18725;
            4'd8:    r = 18'd16384;
            4'd9:    r = 18'd14564;
            default: r = 18'd131071 + 18'd1;
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/bblur3_front.sv
// Front end: takes pixels, keeps positions and line stores, builds result jobs.
`timescale 1ns / 1ps
module bblur3_front #(
    parameter int MAX_WIDTH  = bblur3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bblur3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    input  logic                              cfg_wr_en,
    input  bblur3_pkg::cfg_index_t            cfg_index,
    input  logic [bblur3_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output logic                              push,
    output bblur3_pkg::q_entry_t              push_entry,
    input  logic                              q_full
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;

    logic [bblur3_pkg::FW_W-1:0] frame_width_reg;
    logic [bblur3_pkg::FH_W-1:0] frame_height_reg;
    logic [CW-1:0]               col_reg, col_next;
    logic [RW-1:0]               row_reg, row_next;
    logic [31:0]                 w_eff, h_eff;
    logic                        row_end, last_row, accept;

    // Line stores
    bblur3_pkg::pix_t older_mem [MAX_WIDTH];
    bblur3_pkg::pix_t newer_mem [MAX_WIDTH];
    bblur3_pkg::pix_t old_rd_reg, new_rd_reg;

    // Work stage
    logic                  st_valid_reg;
    bblur3_pkg::pix_t      st_pix_reg;
    logic [CW-1:0]         st_col_reg;
    logic                  st_c1_reg, st_c2_reg, st_r1_reg, st_r2_reg;
    logic                  st_last_row_reg, st_row_end_reg;
    logic                  byp_reg;
    bblur3_pkg::pix_t      fwd_old_reg, fwd_new_reg;
    bblur3_pkg::pix_t      eff_old, eff_new;
    bblur3_pkg::pix_t      win_reg [6];
    logic                  st_go, any_job;
    logic [2:0]            cm_a, cm_b, rm_up, rm_lo;

    // Clamp the frame size registers
    always_comb begin
        if (frame_width_reg == '0) begin
            w_eff = 32'd1;
        end else if (32'(frame_width_reg) > 32'(MAX_WIDTH)) begin
            w_eff = 32'(MAX_WIDTH);
        end else begin
            w_eff = 32'(frame_width_reg);
        end
        if (frame_height_reg == '0) begin
            h_eff = 32'd1;
        end else if (32'(frame_height_reg) > 32'(MAX_HEIGHT)) begin
            h_eff = 32'(MAX_HEIGHT);
        end else begin
            h_eff = 32'(frame_height_reg);
        end
    end

    assign row_end  = (32'(col_reg) + 32'd1) >= w_eff;
    assign last_row = (32'(row_reg) + 32'd1) >= h_eff;
    assign accept   = s_tvalid && s_tready;

    assign st_go    = st_valid_reg && (!any_job || !q_full);
    assign s_tready = !st_valid_reg || st_go;
    assign push     = st_valid_reg && any_job && !q_full;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= bblur3_pkg::FRAME_WIDTH_RST;
            frame_height_reg <= bblur3_pkg::FRAME_HEIGHT_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                bblur3_pkg::REG_FRAME_WIDTH:
                    frame_width_reg <= cfg_wdata[bblur3_pkg::FW_W-1:0];
                bblur3_pkg::REG_FRAME_HEIGHT:
                    frame_height_reg <= cfg_wdata[bblur3_pkg::FH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (row_end) begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + RW'(1);
            end else begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
        end else if (cfg_wr_en) begin
            col_reg <= '0;
            row_reg <= '0;
        end else begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Store read on accept; write-back when the word leaves the work stage
    always_ff @(posedge aclk) begin
        if (accept) begin
            old_rd_reg <= older_mem[col_reg];
            new_rd_reg <= newer_mem[col_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (st_go) begin
            older_mem[st_col_reg] <= eff_new;
            newer_mem[st_col_reg] <= st_pix_reg;
        end
    end

    // Same column read while written (one-pixel rows): forward the new data
    assign eff_old = byp_reg ? fwd_old_reg : old_rd_reg;
    assign eff_new = byp_reg ? fwd_new_reg : new_rd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (accept) begin
            st_valid_reg <= 1'b1;
        end else if (st_go) begin
            st_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            st_pix_reg      <= {s_tdata[7:0], s_tdata[15:8], s_tdata[23:16]};
            st_col_reg      <= col_reg;
            st_c1_reg       <= (col_reg != '0);
            st_c2_reg       <= (32'(col_reg) >= 32'd2);
            st_r1_reg       <= (row_reg != '0);
            st_r2_reg       <= (32'(row_reg) >= 32'd2);
            st_last_row_reg <= last_row;
            st_row_end_reg  <= row_end;
            byp_reg         <= st_valid_reg && (st_col_reg == col_reg);
            fwd_old_reg     <= eff_new;
            fwd_new_reg     <= st_pix_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 6; i++) begin
                win_reg[i] <= '0;
            end
        end else if (st_go) begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= eff_old;
            win_reg[4] <= eff_new;
            win_reg[5] <= st_pix_reg;
        end
    end

    // Result jobs in output order
    always_comb begin
        cm_a  = {1'b1, 1'b1, st_c2_reg};
        cm_b  = {1'b1, st_c1_reg, 1'b0};
        rm_up = {1'b1, 1'b1, st_r2_reg};
        rm_lo = {1'b1, st_r1_reg, 1'b0};

        push_entry.job[0] = '{valid: st_c1_reg && st_r1_reg, col_mask: cm_a,
                              row_mask: rm_up, flast: 1'b0};
        push_entry.job[1] = '{valid: st_c1_reg && st_last_row_reg, col_mask: cm_a,
                              row_mask: rm_lo, flast: 1'b0};
        push_entry.job[2] = '{valid: st_row_end_reg && st_r1_reg, col_mask: cm_b,
                              row_mask: rm_up, flast: 1'b0};
        push_entry.job[3] = '{valid: st_row_end_reg && st_last_row_reg, col_mask: cm_b,
                              row_mask: rm_lo, flast: 1'b1};

        for (int i = 0; i < 6; i++) begin
            push_entry.pix[i] = win_reg[i];
        end
        push_entry.pix[6] = eff_old;
        push_entry.pix[7] = eff_new;
        push_entry.pix[8] = st_pix_reg;

        any_job = push_entry.job[0].valid || push_entry.job[1].valid ||
                  push_entry.job[2].valid || push_entry.job[3].valid;
    end

endmodule

FILE: rtl/core/bblur3_queue.sv
// Job queue between front and back end.
`timescale 1ns / 1ps
module bblur3_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  bblur3_pkg::q_entry_t push_entry,
    output logic                 q_full,
    input  logic                 pop,
    output bblur3_pkg::q_entry_t head_entry,
    output logic                 q_empty
);

    bblur3_pkg::q_entry_t       mem_reg [bblur3_pkg::QDEPTH];
    logic [bblur3_pkg::QPW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [bblur3_pkg::QPW:0]   count_reg;

    assign q_full     = (count_reg == (bblur3_pkg::QPW+1)'(bblur3_pkg::QDEPTH));
    assign q_empty    = (count_reg == '0);
    assign head_entry = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + bblur3_pkg::QPW'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + bblur3_pkg::QPW'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + (bblur3_pkg::QPW+1)'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - (bblur3_pkg::QPW+1)'(1);
            end
        end
    end

endmodule

FILE: rtl/core/bblur3_back.sv
// Back: masked sums, rounded mean by reciprocal; one result per cycle if ready.
`timescale 1ns / 1ps
module bblur3_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bblur3_pkg::q_entry_t head_entry,
    input  logic                 q_empty,
    output logic                 pop,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,
    output logic                 m_tlast,
    output logic                 m_tuser
);

    logic                  en, issue, is_last;
    logic [3:0]            vld, remaining, pick, done_reg;
    bblur3_pkg::job_t      sel;
    logic [bblur3_pkg::COL_SUM_W-1:0] col_sum [3][3];
    logic [bblur3_pkg::SUM_W-1:0]     tot [3];
    logic [1:0]            n_cols, n_rows;
    logic [3:0]            cnt;

    logic                            b1_valid_reg, b1_last_reg, b1_flast_reg;
    logic [bblur3_pkg::NUM_W-1:0]    num_reg [3];
    logic [bblur3_pkg::RECIP_W-1:0]  recip_reg;
    logic [bblur3_pkg::NUM_W+bblur3_pkg::RECIP_W-1:0] prod [3];

    logic        m_valid_reg, m_last_reg, m_user_reg;
    logic [23:0] m_data_reg;

    assign en = !m_valid_reg || m_tready;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            vld[i] = head_entry.job[i].valid;
        end
        remaining = vld & ~done_reg;
        pick      = remaining & (~remaining + 4'd1);
        is_last   = (remaining & ~pick) == 4'd0;
        issue     = en && !q_empty;
        pop       = issue && is_last;

        sel = '0;
        for (int i = 0; i < 4; i++) begin
            if (pick[i]) begin
                sel = sel | head_entry.job[i];
            end
        end

        n_cols = 2'(sel.col_mask[0]) + 2'(sel.col_mask[1]) + 2'(sel.col_mask[2]);
        n_rows = 2'(sel.row_mask[0]) + 2'(sel.row_mask[1]) + 2'(sel.row_mask[2]);
        cnt    = 4'(n_cols) * 4'(n_rows);

        // ch 0 red, 1 green, 2 blue; k column, r row
        for (int ch = 0; ch < 3; ch++) begin
            for (int k = 0; k < 3; k++) begin
                col_sum[ch][k] = '0;
                for (int r = 0; r < 3; r++) begin
                    if (sel.row_mask[r]) begin
                        col_sum[ch][k] = col_sum[ch][k] +
                            bblur3_pkg::COL_SUM_W'(head_entry.pix[k*3+r][23-8*ch -: 8]);
                    end
                end
            end
            tot[ch] = '0;
            for (int k = 0; k < 3; k++) begin
                if (sel.col_mask[k]) begin
                    tot[ch] = tot[ch] + bblur3_pkg::SUM_W'(col_sum[ch][k]);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= '0;
        end else if (issue) begin
            done_reg <= is_last ? 4'd0 : (done_reg | pick);
        end
    end

    // Sum stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b1_valid_reg <= 1'b0;
        end else if (en) begin
            b1_valid_reg <= issue;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                num_reg[ch] <= {tot[ch], 1'b0} + bblur3_pkg::NUM_W'(cnt);
            end
            recip_reg    <= bblur3_pkg::recip(cnt);
            b1_last_reg  <= is_last;
            b1_flast_reg <= sel.flast;
        end
    end

    // Divide stage feeding the output register
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            prod[ch] = (bblur3_pkg::NUM_W+bblur3_pkg::RECIP_W)'(num_reg[ch]) *
                       (bblur3_pkg::NUM_W+bblur3_pkg::RECIP_W)'(recip_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= b1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int ch = 0; ch < 3; ch++) begin
                m_data_reg[8*ch +: 8] <= prod[ch][bblur3_pkg::RECIP_SHIFT +: 8];
            end
            m_last_reg <= b1_last_reg;
            m_user_reg <= b1_flast_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = m_user_reg;

endmodule

FILE: rtl/core/box_blur_3x3_clipped_core.sv
// Top level of the streaming 3x3 box blur core with frame-edge clipping.
`timescale 1ns / 1ps
// Usage
//   s_ side: RGB pixels in raster order, one word per handshake.
//   m_ side: blurred pixels; m_tlast ends the group of results a single input
//   word causes, m_tuser flags the final pixel of the frame.
//   cfg port: register 0 frame width, register 1 frame height; a write also
//   restarts the frame at row 0, column 0. Write only while the core is idle.
// Throughput
//   One pixel per cycle away from the last row and row ends while m_tready
//   is high: at most one result. A last-row word gives up to two results, a
//   row-closing word up to two, four in the last row; the back end issues one
//   result per cycle while m_tready is high, so such words slow the input.
// Result path
//   A result passes work stage, job queue, sum stage and output register after
//   its closing word; an inner pixel's window closes a row and a pixel later.
// Reset
//   Synchronous, active low. Size registers return to 640 x 480, positions
//   and the queue clear; line stores are left as they are.
// Stalls
//   A four-deep job queue parts the front from the back: m_tready low holds
//   the output word, fills the queue, and only then drops s_tready.
module box_blur_3x3_clipped_core #(
    parameter int MAX_WIDTH  = bblur3_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = bblur3_pkg::DEF_MAX_HEIGHT
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: in_red [7:0], in_green [15:8], in_blue [23:16]
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [23:0]                       s_tdata,
    // m_tdata: out_red [7:0], out_green [15:8], out_blue [23:16]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [23:0]                       m_tdata,
    output logic                              m_tlast,   // run_last
    output logic                              m_tuser,   // frame_last
    input  logic                              cfg_wr_en,
    input  bblur3_pkg::cfg_index_t            cfg_index,
    input  logic [bblur3_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic                 push, q_full, pop, q_empty;
    bblur3_pkg::q_entry_t push_entry, head_entry;

    // Front: positions, line stores, window, job classification
    bblur3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Window plus up to four jobs per word
    bblur3_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full),
        .pop        (pop),
        .head_entry (head_entry),
        .q_empty    (q_empty)
    );

    // Back: sums, rounded mean, output register
    bblur3_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_entry (head_entry),
        .q_empty    (q_empty),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

FILE: rtl/core/bblur3_checker.sv
// Port checker for the box blur core, bound to the top level.
`timescale 1ns / 1ps
`include "box_blur_3x3_clipped_core_macros.svh"
module bblur3_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser
);

    `BBC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser), "stalled result word changed")

    `BBC_ASSERT_NOW(a_flast_ends_run, aclk, aresetn, m_tvalid && m_tuser, m_tlast, "frame end not at end of run")

    `BBC_ASSERT_NOW(a_reset_idle, aclk, aresetn, $rose(aresetn), s_tready && !m_tvalid, "core not idle after reset")

endmodule

bind box_blur_3x3_clipped_core bblur3_checker u_bblur3_checker (.*);
